@@ rtl/clsm_pkg.sv @@
// Shared constants, field layout and modular helpers for the cubic Legendre sum block.
// No dependencies; imported by the top level and by its port checker.
package clsm_pkg;

    // field widths
    localparam int DW  = 12;    // prime, t and coefficient width
    localparam int SW  = 13;    // symbol sum, signed
    localparam int M1W = 26;    // first moment, signed
    localparam int M2W = 37;    // second moment, unsigned
    localparam int M3W = 50;    // third moment, signed
    localparam int SQW = 26;    // symbol sum squared, signed product
    localparam int CUW = 39;    // symbol sum cubed, signed product

    // defaults for the top-level parameters
    localparam int DEF_MAX_PRIME    = 4096;
    localparam int DEF_MOMENT_COUNT = 3;

    // stream layout
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_M1_LSB  = SW;
    localparam int OUT_M2_LSB  = SW + M1W;
    localparam int OUT_M3_LSB  = SW + M1W + M2W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_M3_LSB - M3W;

    // saturation limits
    localparam logic signed [M1W:0] M1_LIM = (M1W+1)'(64'sd16777216);
    localparam logic        [M2W:0] M2_LIM = (M2W+1)'(64'd68719476736);
    localparam logic signed [M3W:0] M3_LIM = (M3W+1)'(64'sd281474976710656);

    // smallest legal modulus
    localparam logic [DW-1:0] MIN_PRIME = DW'(3);

    // (x + y) mod p for x, y already below p
    function automatic logic [DW-1:0] mod_add(input logic [DW-1:0] x,
                                              input logic [DW-1:0] y,
                                              input logic [DW-1:0] p);
        logic [DW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[DW-1:0];
    endfunction

endpackage

@@ rtl/cubic_legendre_sum_moments.sv @@
// Top level: Legendre symbol sum of a cubic over a prime field, with running power sums.
// Depends on clsm_pkg; holds the residue table memory and the whole sequencer.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+------------------------------------------
//  s_axis   | in  | i_s_axis_tvalid/o_s_axis_tready | tdata: t, a, b, c; tuser: first_t
//  m_axis   | out | o_m_axis_tvalid/i_m_axis_tready | tdata: sum, moment 1, 2, 3
//  cfg      | in  | i_cfg_we (no back pressure)  | i_cfg_wdata: prime modulus
//
//  One beat at a time. Per beat: accept, reduce a, b, c (one bit a cycle), one setup step,
//  one table read per x below p, a drain step, square, cube and update steps, then load the output.
//  A first_t beat first clears the table below p and then marks the squares.
//  The table read loop over x (one memory read per cycle) dominates each beat.
//  A beat with t at or above p skips the sum: accept, any rebuild, then load.
//  Reset is synchronous, active low; the table is not cleared by reset, only rebuilt.
//  Entries at or above the modulus of the last rebuild read as zero.
//  A stalled output holds the sequencer in its final state; input waits until idle.
module cubic_legendre_sum_moments
    import clsm_pkg::*;
#(
    parameter int MAX_PRIME    = DEF_MAX_PRIME,
    parameter int MOMENT_COUNT = DEF_MOMENT_COUNT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config
    input  logic                   i_cfg_we,
    input  logic [DW-1:0]          i_cfg_wdata,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // t_value, coef_a, coef_b, coef_c
    input  logic                   i_s_axis_tuser,   // first_t
    // output stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // symbol_sum, moment_one/two/three, pad
);

    localparam int AW = $clog2(MAX_PRIME);
    localparam logic [16:0] PMAX = 17'(MAX_PRIME - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_MARK  = 4'd2;
    localparam logic [3:0] S_RED   = 4'd3;
    localparam logic [3:0] S_PRE   = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_SQ    = 4'd7;
    localparam logic [3:0] S_CUBE  = 4'd8;
    localparam logic [3:0] S_UPD   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    localparam logic [1:0] IDX_A = 2'd0;
    localparam logic [1:0] IDX_B = 2'd1;
    localparam logic [1:0] IDX_C = 2'd2;

    // registers
    logic [3:0]             r_state, n_state;
    logic [DW-1:0]          r_prime;
    logic [DW-1:0]          r_p, n_p;
    logic [DW-1:0]          r_bp, n_bp;
    logic [DW-1:0]          r_t, n_t;
    logic [DW-1:0]          r_ca, n_ca, r_cb, n_cb, r_cc, n_cc;
    logic [DW-1:0]          r_cnt, n_cnt;
    logic [DW-1:0]          r_odd, n_odd;
    logic [DW-1:0]          r_s, n_s;
    logic [DW-1:0]          r_rem, n_rem;
    logic [DW-1:0]          r_shift, n_shift;
    logic [3:0]             r_bit, n_bit;
    logic [1:0]             r_idx, n_idx;
    logic [DW-1:0]          r_f, n_f, r_d1, n_d1, r_d2, n_d2, r_six, n_six;
    logic                   r_rd_v, n_rd_v;
    logic                   r_rd_nz, n_rd_nz;
    logic                   r_rd_in, n_rd_in;
    logic signed [SW-1:0]   r_sym, n_sym;
    logic signed [SQW-1:0]  r_sq;
    logic signed [CUW-1:0]  r_cube;
    logic signed [M1W-1:0]  r_m1, n_m1;
    logic        [M2W-1:0]  r_m2, n_m2;
    logic signed [M3W-1:0]  r_m3, n_m3;
    logic                   r_out_v, n_out_v;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // residue table memory
    logic                   r_tbl [MAX_PRIME];
    logic                   r_tbl_q;
    logic                   tbl_we;
    logic                   tbl_wd;
    logic [AW-1:0]          tbl_waddr;
    logic [AW-1:0]          tbl_raddr;

    // combinational helpers
    logic [DW-1:0]          p_eff;
    logic [DW:0]            rem_sh;
    logic [DW-1:0]          rem_new;
    logic [DW-1:0]          s_new;
    logic [DW-1:0]          six_m;
    logic [DW-1:0]          d1_init;
    logic [DW-1:0]          d2_init;
    logic [DW-1:0]          src_next;
    logic signed [M1W:0]    m1_sum;
    logic        [M2W:0]    m2_sum;
    logic signed [M3W:0]    m3_sum;

    // clamp the configured modulus into the supported range
    always_comb begin
        if (r_prime < MIN_PRIME) begin
            p_eff = MIN_PRIME;
        end else if ({5'd0, r_prime} > PMAX) begin
            p_eff = DW'(PMAX);
        end else begin
            p_eff = r_prime;
        end
    end

    // one restoring remainder step, one bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_shift[DW-1]};
        if (rem_sh >= {1'b0, r_p}) begin
            rem_new = DW'(rem_sh - {1'b0, r_p});
        end else begin
            rem_new = rem_sh[DW-1:0];
        end
    end

    // next coefficient to reduce
    always_comb begin
        case (r_idx)
            IDX_A:   src_next = r_cb;
            IDX_B:   src_next = r_cc;
            default: src_next = r_cc;
        endcase
    end

    // 6 mod p and the initial finite differences of the cubic
    always_comb begin
        six_m = DW'(6);
        if (six_m >= r_p) begin
            six_m = six_m - r_p;
        end
        if (six_m >= r_p) begin
            six_m = six_m - r_p;
        end
        d1_init = mod_add(mod_add(DW'(1), r_ca, r_p), r_cb, r_p);
        d2_init = mod_add(mod_add(r_ca, r_ca, r_p), six_m, r_p);
    end

    assign s_new = mod_add(r_s, r_odd, r_p);

    // saturating moment sums
    always_comb begin
        m1_sum = (M1W+1)'(r_m1) + (M1W+1)'(r_sym);
        m2_sum = (M2W+1)'(r_m2) + (M2W+1)'($unsigned(r_sq));
        m3_sum = (M3W+1)'(r_m3) + (M3W+1)'(r_cube);
    end

    // main sequencer
    always_comb begin
        n_state    = r_state;
        n_p        = r_p;
        n_bp       = r_bp;
        n_t        = r_t;
        n_ca       = r_ca;
        n_cb       = r_cb;
        n_cc       = r_cc;
        n_cnt      = r_cnt;
        n_odd      = r_odd;
        n_s        = r_s;
        n_rem      = r_rem;
        n_shift    = r_shift;
        n_bit      = r_bit;
        n_idx      = r_idx;
        n_f        = r_f;
        n_d1       = r_d1;
        n_d2       = r_d2;
        n_six      = r_six;
        n_rd_v     = 1'b0;
        n_rd_nz    = 1'b0;
        n_rd_in    = 1'b0;
        n_sym      = r_sym;
        n_m1       = r_m1;
        n_m2       = r_m2;
        n_m3       = r_m3;
        n_out_v    = r_out_v;
        n_out_data = r_out_data;
        tbl_we     = 1'b0;
        tbl_wd     = 1'b0;
        tbl_waddr  = AW'(r_cnt);

        if (r_out_v && i_m_axis_tready) begin
            n_out_v = 1'b0;
        end

        // table read results arrive in the cycle after the address;
        // entries outside the last build read as zero, so a nonzero value there counts as a non-square
        if (r_rd_v) begin
            if (r_tbl_q && r_rd_in) begin
                n_sym = r_sym + SW'(1);
            end else if (r_rd_nz) begin
                n_sym = r_sym - SW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_p     = p_eff;
                    n_t     = i_s_axis_tdata[DW-1:0];
                    n_ca    = i_s_axis_tdata[2*DW-1:DW];
                    n_cb    = i_s_axis_tdata[3*DW-1:2*DW];
                    n_cc    = i_s_axis_tdata[4*DW-1:3*DW];
                    n_sym   = '0;
                    n_rem   = '0;
                    n_shift = i_s_axis_tdata[2*DW-1:DW];
                    n_bit   = '0;
                    n_idx   = IDX_A;
                    n_cnt   = '0;
                    if (i_s_axis_tuser) begin
                        n_m1    = '0;
                        n_m2    = '0;
                        n_m3    = '0;
                        n_bp    = p_eff;
                        n_state = S_CLR;
                    end else if (i_s_axis_tdata[DW-1:0] < p_eff) begin
                        n_state = S_RED;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            // zero every entry below p
            S_CLR: begin
                tbl_we    = 1'b1;
                tbl_wd    = 1'b0;
                tbl_waddr = AW'(r_cnt);
                n_cnt     = r_cnt + DW'(1);
                if (r_cnt == r_p - DW'(1)) begin
                    n_odd   = DW'(1);
                    n_s     = '0;
                    n_state = S_MARK;
                end
            end

            // running sums of odd numbers land on the squares
            S_MARK: begin
                if (r_odd <= r_p - DW'(2)) begin
                    tbl_we    = 1'b1;
                    tbl_wd    = 1'b1;
                    tbl_waddr = AW'(s_new);
                    n_s       = s_new;
                    n_odd     = r_odd + DW'(2);
                end else if (r_t < r_p) begin
                    n_state = S_RED;
                end else begin
                    n_state = S_DONE;
                end
            end

            // reduce a, b, c modulo p in turn
            S_RED: begin
                n_rem   = rem_new;
                n_shift = {r_shift[DW-2:0], 1'b0};
                n_bit   = r_bit + 4'd1;
                if (r_bit == 4'(DW - 1)) begin
                    n_rem   = '0;
                    n_bit   = '0;
                    n_shift = src_next;
                    n_idx   = r_idx + 2'd1;
                    case (r_idx)
                        IDX_A:   n_ca = rem_new;
                        IDX_B:   n_cb = rem_new;
                        default: n_cc = rem_new;
                    endcase
                    if (r_idx == IDX_C) begin
                        n_state = S_PRE;
                    end
                end
            end

            // f(0) = c, first and second differences at x = 0
            S_PRE: begin
                n_f     = r_cc;
                n_d1    = d1_init;
                n_d2    = d2_init;
                n_six   = six_m;
                n_cnt   = '0;
                n_state = S_EVAL;
            end

            // one table read per x, cubic stepped by finite differences
            S_EVAL: begin
                n_rd_v  = 1'b1;
                n_rd_nz = (r_f != '0);
                n_rd_in = (r_f < r_bp);
                n_f     = mod_add(r_f, r_d1, r_p);
                n_d1    = mod_add(r_d1, r_d2, r_p);
                n_d2    = mod_add(r_d2, r_six, r_p);
                n_cnt   = r_cnt + DW'(1);
                if (r_cnt == r_p - DW'(1)) begin
                    n_state = S_DRAIN;
                end
            end

            S_DRAIN: n_state = S_SQ;
            S_SQ:    n_state = S_CUBE;
            S_CUBE:  n_state = S_UPD;

            S_UPD: begin
                if (m1_sum > M1_LIM) begin
                    n_m1 = M1W'(M1_LIM);
                end else if (m1_sum < -M1_LIM) begin
                    n_m1 = M1W'(-M1_LIM);
                end else begin
                    n_m1 = M1W'(m1_sum);
                end
                if (MOMENT_COUNT >= 2) begin
                    if (m2_sum > M2_LIM) begin
                        n_m2 = M2W'(M2_LIM);
                    end else begin
                        n_m2 = M2W'(m2_sum);
                    end
                end
                if (MOMENT_COUNT >= 3) begin
                    if (m3_sum > M3_LIM) begin
                        n_m3 = M3W'(M3_LIM);
                    end else if (m3_sum < -M3_LIM) begin
                        n_m3 = M3W'(-M3_LIM);
                    end else begin
                        n_m3 = M3W'(m3_sum);
                    end
                end
                n_state = S_DONE;
            end

            // hand the beat to the output register once it is free
            S_DONE: begin
                if (!r_out_v || i_m_axis_tready) begin
                    n_out_v    = 1'b1;
                    n_out_data = {{OUT_PAD_W{1'b0}}, r_m3, r_m2, r_m1, r_sym};
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign tbl_raddr = AW'(r_f);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prime <= MIN_PRIME;
            r_bp    <= '0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_m1    <= '0;
            r_m2    <= '0;
            r_m3    <= '0;
        end else begin
            r_state <= n_state;
            r_bp    <= n_bp;
            r_rd_v  <= n_rd_v;
            r_out_v <= n_out_v;
            r_m1    <= n_m1;
            r_m2    <= n_m2;
            r_m3    <= n_m3;
            if (i_cfg_we) begin
                r_prime <= i_cfg_wdata;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_t        <= n_t;
        r_ca       <= n_ca;
        r_cb       <= n_cb;
        r_cc       <= n_cc;
        r_cnt      <= n_cnt;
        r_odd      <= n_odd;
        r_s        <= n_s;
        r_rem      <= n_rem;
        r_shift    <= n_shift;
        r_bit      <= n_bit;
        r_idx      <= n_idx;
        r_f        <= n_f;
        r_d1       <= n_d1;
        r_d2       <= n_d2;
        r_six      <= n_six;
        r_rd_nz    <= n_rd_nz;
        r_rd_in    <= n_rd_in;
        r_sym      <= n_sym;
        r_sq       <= r_sym * r_sym;
        r_cube     <= r_sq * r_sym;
        r_out_data <= n_out_data;
    end

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wd;
        end
        r_tbl_q <= r_tbl[tbl_raddr];
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;

endmodule

@@ rtl/clsm_chk.sv @@
// Port-level checker for cubic_legendre_sum_moments, bound to the top level.
// Depends on clsm_pkg for the output field layout.
module clsm_chk
    import clsm_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic signed [SW-1:0]  chk_sym;
    logic signed [M1W-1:0] chk_m1;
    logic        [M2W-1:0] chk_m2;

    assign chk_sym = o_m_axis_tdata[SW-1:0];
    assign chk_m1  = o_m_axis_tdata[OUT_M1_LSB +: M1W];
    assign chk_m2  = o_m_axis_tdata[OUT_M2_LSB +: M2W];

    // a held output beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output beat changed while stalled");

    // one beat in flight: the input closes right after an accept
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after an accepted beat");

    // symbol sum never reaches the most negative code
    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> chk_sym != -SW'(4096))
        else $error("symbol sum out of range");

    // saturated first and second moments stay inside their limits
    a_mom_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (chk_m1 <= M1W'(M1_LIM)) && (chk_m1 >= -M1W'(M1_LIM))
                            && (chk_m2 <= M2W'(M2_LIM)))
        else $error("moment outside saturation range");

endmodule

bind cubic_legendre_sum_moments clsm_chk u_clsm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
